// File: design/nha_pkg.sv
// Shared types, constants and helpers for the net HPWL accumulator.
package nha_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PIN   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_COORD_BITS  = 20;

    localparam int ID_BITS     = 16;
    localparam int POS_BITS    = 20;  // width of the origin fields on the stream
    localparam int OFFSET_BITS = 16;
    localparam int EPOCH_BITS  = 8;
    localparam int HPWL_BITS   = 22;
    localparam int TOTAL_BITS  = 40;
    localparam int QUEUE_DEPTH = 4;   // power of two, pointers wrap naturally

    localparam logic [HPWL_BITS-1:0]  HPWL_MAX  = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic clear;
        logic last;
    } item_ctl_t;

    // signed width of a pin position: origin plus signed offset, with headroom
    function automatic int pos_bits(input int coord_bits);
        return ((coord_bits > OFFSET_BITS) ? coord_bits : OFFSET_BITS) + 2;
    endfunction

endpackage

// File: design/nha_front.sv
// Front end: accepts commands, owns the origin table and resolves pin positions.
module nha_front
    import nha_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    localparam int PW = pos_bits(COORD_BITS)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  cmd_t                   cmd,
    input  logic [ID_BITS-1:0]     cell_id,
    input  logic [COORD_BITS-1:0]  pos_x,
    input  logic [COORD_BITS-1:0]  pos_y,
    input  logic [OFFSET_BITS-1:0] pin_dx,
    input  logic [OFFSET_BITS-1:0] pin_dy,
    input  logic                   last_pin,
    output logic                   push_valid,
    input  logic                   push_ready,
    output item_ctl_t              push_ctl,
    output logic signed [PW-1:0]   push_px,
    output logic signed [PW-1:0]   push_py
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = EPOCH_BITS + 2 * COORD_BITS;

    // entry = {epoch tag, y, x}; tag 0 never matches the live epoch
    logic [EW-1:0] table_mem [TABLE_DEPTH];
    logic [EW-1:0] rd_data_reg;

    logic                  sweep_reg, sweep_next;
    logic [AW-1:0]         sweep_addr_reg, sweep_addr_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;

    logic                   st_valid_reg, st_valid_next;
    item_ctl_t              st_ctl_reg;
    logic                   st_hit_reg;
    logic [EPOCH_BITS-1:0]  st_epoch_reg;
    logic [OFFSET_BITS-1:0] st_offx_reg, st_offy_reg;

    logic accept, in_range, is_load, is_pin, is_clear;
    logic wr_en, rd_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [EPOCH_BITS-1:0] tag;
    logic [COORD_BITS-1:0] org_x, org_y;
    logic                  found;

    always_comb begin
        is_load  = 1'b0;
        is_pin   = 1'b0;
        is_clear = 1'b0;
        unique case (cmd)
            CMD_LOAD:  is_load  = 1'b1;
            CMD_PIN:   is_pin   = 1'b1;
            CMD_CLEAR: is_clear = 1'b1;
            default: ;
        endcase
    end

    assign in_range = 32'(cell_id) < TABLE_DEPTH;
    assign s_tready = !sweep_reg && (!st_valid_reg || push_ready);
    assign accept   = s_tvalid && s_tready;

    assign wr_en   = sweep_reg || (accept && is_load && in_range);
    assign wr_addr = sweep_reg ? sweep_addr_reg : cell_id[AW-1:0];
    assign wr_data = sweep_reg ? '0 : {epoch_reg, pos_y, pos_x};
    assign rd_en   = accept && is_pin && in_range;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[cell_id[AW-1:0]];
        end
    end

    // a clear bumps the epoch; on wrap the table is swept back to tag 0
    always_comb begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        epoch_next      = epoch_reg;
        if (sweep_reg) begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
            if (sweep_addr_reg == AW'(TABLE_DEPTH - 1)) begin
                sweep_next = 1'b0;
                epoch_next = EPOCH_BITS'(1);
            end
        end else if (accept && is_clear) begin
            if (epoch_reg == '1) begin
                sweep_next      = 1'b1;
                sweep_addr_next = '0;
            end else begin
                epoch_next = epoch_reg + 1'b1;
            end
        end
    end

    // the stage empties on its push, even while a sweep holds the input
    always_comb begin
        st_valid_next = st_valid_reg;
        if (push_valid && push_ready) begin
            st_valid_next = 1'b0;
        end
        if (accept) begin
            st_valid_next = is_pin || is_clear;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            epoch_reg      <= EPOCH_BITS'(1);
            st_valid_reg   <= 1'b0;
        end else begin
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            epoch_reg      <= epoch_next;
            st_valid_reg   <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_ctl_reg   <= '{clear: is_clear, last: last_pin};
            st_hit_reg   <= in_range;
            st_epoch_reg <= epoch_reg;
            st_offx_reg  <= pin_dx;
            st_offy_reg  <= pin_dy;
        end
    end

    assign tag   = rd_data_reg[EW-1 -: EPOCH_BITS];
    assign org_x = rd_data_reg[COORD_BITS-1:0];
    assign org_y = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign found = st_hit_reg && (tag == st_epoch_reg);

    always_comb begin
        push_px = '0;
        push_py = '0;
        if (found) begin
            push_px = {{(PW-COORD_BITS){1'b0}}, org_x}
                    + {{(PW-OFFSET_BITS){st_offx_reg[OFFSET_BITS-1]}}, st_offx_reg};
            push_py = {{(PW-COORD_BITS){1'b0}}, org_y}
                    + {{(PW-OFFSET_BITS){st_offy_reg[OFFSET_BITS-1]}}, st_offy_reg};
        end
    end

    assign push_valid = st_valid_reg;
    assign push_ctl   = st_ctl_reg;

endmodule

// File: design/nha_queue.sv
// Small FIFO decoupling the front end from the box and total pipeline.
module nha_queue
    import nha_pkg::*;
#(
    parameter int W = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int PTR = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]   slots [QUEUE_DEPTH];
    logic [PTR-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = count_reg != CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + CW'(do_push) - CW'(do_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/nha_back.sv
// Back end: bounding box per net, wirelength, saturating total and output register.
module nha_back
    import nha_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int PW = pos_bits(COORD_BITS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  item_ctl_t             q_ctl,
    input  logic signed [PW-1:0]  q_px,
    input  logic signed [PW-1:0]  q_py,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [HPWL_BITS-1:0]  net_hpwl,
    output logic [TOTAL_BITS-1:0] total_hpwl
);

    localparam int HW = PW + 1;

    logic en, pop, pin;

    logic                 open_reg, open_next;
    logic signed [PW-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [PW-1:0] minx_next, maxx_next, miny_next, maxy_next;

    logic                 b_valid_reg, b_valid_next;
    logic                 b_clear_reg;
    logic signed [PW-1:0] b_minx_reg, b_maxx_reg, b_miny_reg, b_maxy_reg;
    logic [PW-1:0]        dx, dy;
    logic [HW-1:0]        b_hpwl;

    logic                 c_valid_reg, c_valid_next;
    logic                 c_clear_reg;
    logic [HW-1:0]        c_hpwl_reg;

    logic [TOTAL_BITS:0]   sum;
    logic [TOTAL_BITS-1:0] total_reg, total_next, sat_total;
    logic                  m_valid_reg, m_valid_next;
    logic [HPWL_BITS-1:0]  hpwl_out_reg;
    logic [TOTAL_BITS-1:0] total_out_reg;

    // whole pipeline advances when the output slot is free or being drained
    assign en      = !m_valid_reg || m_tready;
    assign q_ready = en;
    assign pop     = en && q_valid;
    assign pin     = pop && !q_ctl.clear;

    // first pin of a net seeds the box
    always_comb begin
        minx_next = minx_reg;
        maxx_next = maxx_reg;
        miny_next = miny_reg;
        maxy_next = maxy_reg;
        open_next = open_reg;
        if (pin) begin
            open_next = !q_ctl.last;
            if (!open_reg) begin
                minx_next = q_px;
                maxx_next = q_px;
                miny_next = q_py;
                maxy_next = q_py;
            end else begin
                minx_next = (q_px < minx_reg) ? q_px : minx_reg;
                maxx_next = (q_px > maxx_reg) ? q_px : maxx_reg;
                miny_next = (q_py < miny_reg) ? q_py : miny_reg;
                maxy_next = (q_py > maxy_reg) ? q_py : maxy_reg;
            end
        end
    end

    assign b_valid_next = en ? (pop && (q_ctl.clear || q_ctl.last)) : b_valid_reg;
    assign c_valid_next = en ? b_valid_reg : c_valid_reg;

    assign dx     = PW'(b_maxx_reg - b_minx_reg);
    assign dy     = PW'(b_maxy_reg - b_miny_reg);
    assign b_hpwl = {1'b0, dx} + {1'b0, dy};

    assign sum       = (TOTAL_BITS + 1)'(total_reg) + (TOTAL_BITS + 1)'(c_hpwl_reg);
    assign sat_total = (sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

    always_comb begin
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        if (en) begin
            m_valid_next = c_valid_reg && !c_clear_reg;
            if (c_valid_reg) begin
                total_next = c_clear_reg ? '0 : sat_total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            minx_reg    <= '0;
            maxx_reg    <= '0;
            miny_reg    <= '0;
            maxy_reg    <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            open_reg    <= open_next;
            minx_reg    <= minx_next;
            maxx_reg    <= maxx_next;
            miny_reg    <= miny_next;
            maxy_reg    <= maxy_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b_clear_reg <= q_ctl.clear;
            b_minx_reg  <= minx_next;
            b_maxx_reg  <= maxx_next;
            b_miny_reg  <= miny_next;
            b_maxy_reg  <= maxy_next;
        end
        if (en) begin
            c_clear_reg <= b_clear_reg;
            c_hpwl_reg  <= b_hpwl;
        end
        if (en && c_valid_reg && !c_clear_reg) begin
            hpwl_out_reg  <= (64'(c_hpwl_reg) > 64'(HPWL_MAX)) ? HPWL_MAX
                                                               : HPWL_BITS'(c_hpwl_reg);
            total_out_reg <= sat_total;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign net_hpwl   = hpwl_out_reg;
    assign total_hpwl = total_out_reg;

endmodule

// File: design/net_hpwl_accumulator_core.sv
// Top level of the net HPWL accumulator: stream ports, front end, queue, back end.
//
// Input stream (s_*): one command per transfer. tuser carries the command
// (load cell origin, net pin, clear), tlast marks a net's final pin. A load
// writes the origin table, a pin looks up its cell and extends the net's box,
// a clear empties the table and zeroes the running total.
// Output stream (m_*): one transfer per finished net, carrying the net's
// half-perimeter wirelength (saturated to 22 bits) and the saturating total.
// Throughput: one command per cycle while s_tready is high. The table is a
// single-port-write, registered-read memory; a pin resolves in the cycle after
// its read, crosses a four-entry queue, then takes two register stages (box,
// wirelength) before the output register, which loads together with the total
// and raises m_tvalid.
// Reset: control state clears and the table is swept, one entry a cycle, through
// all TABLE_DEPTH entries with s_tready low. Every 255th clear repeats that sweep.
// Receiver stall: the back end holds, the queue fills, then s_tready drops;
// a waiting result stays registered on m_tdata until taken.
module net_hpwl_accumulator_core
    import nha_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    localparam int IN_BITS  = ID_BITS + 2 * POS_BITS + 2 * OFFSET_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = HPWL_BITS + TOTAL_BITS,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cell_id, pos_x, pos_y, pin_dx, pin_dy, pad
    input  logic [1:0]       s_tuser,   // cmd
    input  logic             s_tlast,   // last_pin
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // net_hpwl, total_hpwl, pad
);

    localparam int PW  = pos_bits(COORD_BITS);
    localparam int QW  = $bits(item_ctl_t) + 2 * PW;
    localparam int PXO = ID_BITS;
    localparam int PYO = PXO + POS_BITS;
    localparam int OXO = PYO + POS_BITS;
    localparam int OYO = OXO + OFFSET_BITS;

    logic                 push_valid, push_ready;
    item_ctl_t            push_ctl;
    logic signed [PW-1:0] push_px, push_py;
    logic [QW-1:0]        push_data, pop_data;
    logic                 pop_valid, pop_ready;
    item_ctl_t            pop_ctl;
    logic signed [PW-1:0] pop_px, pop_py;

    logic [HPWL_BITS-1:0]  net_hpwl;
    logic [TOTAL_BITS-1:0] total_hpwl;

    nha_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .cmd        (cmd_t'(s_tuser)),
        .cell_id    (s_tdata[ID_BITS-1:0]),
        .pos_x      (COORD_BITS'(s_tdata[PXO +: POS_BITS])),
        .pos_y      (COORD_BITS'(s_tdata[PYO +: POS_BITS])),
        .pin_dx     (s_tdata[OXO +: OFFSET_BITS]),
        .pin_dy     (s_tdata[OYO +: OFFSET_BITS]),
        .last_pin   (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_px    (push_px),
        .push_py    (push_py)
    );

    assign push_data = {push_ctl, push_px, push_py};

    nha_queue #(
        .W (QW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_ctl = item_ctl_t'(pop_data[QW-1 -: $bits(item_ctl_t)]);
    assign pop_px  = pop_data[2*PW-1:PW];
    assign pop_py  = pop_data[PW-1:0];

    nha_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_ctl      (pop_ctl),
        .q_px       (pop_px),
        .q_py       (pop_py),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .net_hpwl   (net_hpwl),
        .total_hpwl (total_hpwl)
    );

    assign m_tdata = {{(OUT_W-OUT_BITS){1'b0}}, total_hpwl, net_hpwl};

endmodule
